[hw/rtl/sss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective scan package
// Shared constants, controller/datapath command and status types, and the
// elaboration-time exponential used to build the decay table.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int MaxStatesDefault  = 16;
  localparam int ExpDepthDefault   = 256;
  localparam int StateSizeW        = 5;
  localparam int StateSizeReset    = 16;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic mul_en;
    logic exp_en;
    logic upd_en;
    logic acc_en;
    logic emit_en;
  } sss_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip;
    logic last;
    logic out_free;
  } sss_status_t;

  // exp(-t) for t in Q8.24 (0..16.0); result Q0.16, up to 65536.
  function automatic logic [16:0] exp_neg_q16(input longint t);
    longint y;
    longint term;
    longint sum;
    longint unsigned s;
    y    = t >>> 2;
    term = 64'sd1 <<< 30;
    sum  = term;
    term = ((term * y) >>> 30) / 1;  sum = sum - term;
    term = ((term * y) >>> 30) / 2;  sum = sum + term;
    term = ((term * y) >>> 30) / 3;  sum = sum - term;
    term = ((term * y) >>> 30) / 4;  sum = sum + term;
    term = ((term * y) >>> 30) / 5;  sum = sum - term;
    term = ((term * y) >>> 30) / 6;  sum = sum + term;
    term = ((term * y) >>> 30) / 7;  sum = sum - term;
    term = ((term * y) >>> 30) / 8;  sum = sum + term;
    s = (sum < 0) ? 64'd0 : 64'(sum);
    for (int k = 0; k < 8; k++) begin
      s = (s * s + (64'd1 << 29)) >> 30;
    end
    s = (s + (64'd1 << 13)) >> 14;
    return s[16:0];
  endfunction

endpackage

[hw/rtl/sss_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective scan input channel
// One beat carries one state element of one time step.
// ----------------------------------------------------------------------------
interface sss_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] u_sample;
  logic signed [15:0] step_size;
  logic signed [15:0] decay_rate;
  logic signed [15:0] b_value;
  logic signed [15:0] c_value;
  logic signed [15:0] skip_gain;
  logic        [3:0]  elem_index;
  logic               start_of_sequence;

  modport source (
    output valid, u_sample, step_size, decay_rate, b_value, c_value, skip_gain,
           elem_index, start_of_sequence,
    input  ready
  );
  modport sink (
    input  valid, u_sample, step_size, decay_rate, b_value, c_value, skip_gain,
           elem_index, start_of_sequence,
    output ready
  );
endinterface

[hw/rtl/sss_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective scan output channel
// One beat carries the scan output of one time step.
// ----------------------------------------------------------------------------
interface sss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] y_out;
  logic               overflow;

  modport source (output valid, y_out, overflow, input ready);
  modport sink (input valid, y_out, overflow, output ready);
endinterface

[hw/rtl/selective_state_space_scan_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective state-space scan unit
// Fixed-point selective scan of one channel, one state element per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one state element of one time step per beat (Q4.12 operands,
//   element index, start flag). Beats whose index is at or beyond the active
//   state size are taken and dropped at once.
//   out_o carries one beat per time step, after the element state_size-1:
//   y_out in Q8.16, saturated, and an overflow flag for the step.
//   cfg_we_i/cfg_wdata_i write state_size; write it only while idle.
// Timing:
//   A kept element passes through accept, multiply, table lookup, state
//   update and accumulate; the controller steps one element through every
//   datapath stage before it takes the next beat. The last element of a
//   step then passes through an emit state, which holds while the output
//   register is full. A dropped element is taken without leaving idle.
// Reset:
//   Clears the accumulator, sticky overflow flag and output valid flag and
//   sets state_size to 16. Hidden state holds garbage until written; the
//   first step of a sequence must set start_of_sequence.
// Stall:
//   A result waits in the output register; the next elements are still
//   taken and the unit holds only when a new result meets a full register.
// ----------------------------------------------------------------------------
module selective_state_space_scan_unit
  import sss_pkg::*;
#(
  parameter int MAX_STATES      = MaxStatesDefault,
  parameter int EXP_TABLE_DEPTH = ExpDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [StateSizeW-1:0] cfg_wdata_i,
  sss_in_if.sink                in_i,
  sss_out_if.source             out_o
);

  sss_cmd_t    cmd;
  sss_status_t status;

  // sequence each element through the shared datapath
  sss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sss_datapath #(
    .MAX_STATES      (MAX_STATES),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .u_i         (in_i.u_sample),
    .dl_i        (in_i.step_size),
    .a_i         (in_i.decay_rate),
    .b_i         (in_i.b_value),
    .c_i         (in_i.c_value),
    .d_i         (in_i.skip_gain),
    .idx_i       (in_i.elem_index),
    .start_i     (in_i.start_of_sequence),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .y_o         (out_o.y_out),
    .ovf_o       (out_o.overflow)
  );

endmodule

[hw/rtl/sss_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective scan controller
// Sequences one element through multiply, table, update, accumulate, and emit after the last.
// ----------------------------------------------------------------------------
module sss_ctrl
  import sss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sss_status_t status_i,
  output sss_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul  = 6'b000010,
    StExp  = 6'b000100,
    StUpd  = 6'b001000,
    StAcc  = 6'b010000,
    StEmit = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!status_i.skip) state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StExp;
      end
      StExp: begin
        cmd_o.exp_en = 1'b1;
        state_d      = StUpd;
      end
      StUpd: begin
        cmd_o.upd_en = 1'b1;
        state_d      = StAcc;
      end
      StAcc: begin
        cmd_o.acc_en = 1'b1;
        state_d      = status_i.last ? StEmit : StIdle;
      end
      StEmit: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.emit_en = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/sss_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective scan datapath
// Operand registers, decay table, hidden state memory, accumulator, output.
// ----------------------------------------------------------------------------
module sss_datapath
  import sss_pkg::*;
#(
  parameter int MAX_STATES      = MaxStatesDefault,
  parameter int EXP_TABLE_DEPTH = ExpDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [StateSizeW-1:0] cfg_wdata_i,
  input  logic signed [15:0]    u_i,
  input  logic signed [15:0]    dl_i,
  input  logic signed [15:0]    a_i,
  input  logic signed [15:0]    b_i,
  input  logic signed [15:0]    c_i,
  input  logic signed [15:0]    d_i,
  input  logic [3:0]            idx_i,
  input  logic                  start_i,
  input  sss_cmd_t              cmd_i,
  output sss_status_t           status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic signed [31:0]    y_o,
  output logic                  ovf_o
);

  localparam int AW   = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int TIW  = $clog2(EXP_TABLE_DEPTH);
  localparam int TPW  = 29 + TIW + 1;
  localparam longint DenC = longint'(EXP_TABLE_DEPTH - 1);

  // Decay table, built at elaboration
  logic [16:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    localparam longint NumC = longint'(g) * 16 * (64'sd1 <<< 24);
    localparam longint ArgC = (NumC + DenC / 2) / DenC;
    assign exp_rom[g] = exp_neg_q16(ArgC);
  end

  // Configuration
  logic [StateSizeW-1:0] size_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= StateSizeW'(StateSizeReset);
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  logic [8:0] nsz, idx9;
  always_comb begin
    if (size_q == '0) nsz = 9'd1;
    else if ({4'b0, size_q} > 9'(MAX_STATES)) nsz = 9'(MAX_STATES);
    else nsz = {4'b0, size_q};
    idx9 = {5'b0, idx_i};
  end

  // Operand capture
  logic signed [15:0] u_q, dl_q, a_q, b_q, c_q, d_q;
  logic [AW-1:0] addr_q;
  logic start_q, last_q, first_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      u_q <= u_i; dl_q <= dl_i; a_q <= a_i;
      b_q <= b_i; c_q <= c_i; d_q <= d_i;
      addr_q  <= idx9[AW-1:0];
      start_q <= start_i;
      last_q  <= (idx9 == nsz - 9'd1);
      first_q <= (idx_i == 4'd0);
    end
  end

  // Hidden state memory
  logic signed [31:0] mem [MAX_STATES];
  logic signed [31:0] old_q;
  logic signed [31:0] h_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) old_q <= mem[idx9[AW-1:0]];
    if (cmd_i.acc_en) mem[addr_q] <= h_q;
  end

  // Products
  logic signed [31:0] x_q, p_q;
  logic signed [24:0] ud_q;
  logic signed [31:0] ud_full;
  assign ud_full = u_q * d_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      x_q  <= dl_q * a_q;
      p_q  <= dl_q * u_q;
      ud_q <= 25'((33'(ud_full) + 33'sd128) >>> 8);
    end
  end

  // Table lookup and input term
  logic [32:0]     t_abs;
  logic [28:0]     t_cl;
  logic [TPW-1:0]  t_prod;
  logic [TIW-1:0]  ti;
  logic [16:0]     e_q;
  logic signed [47:0] pb_q;
  always_comb begin
    t_abs  = 33'(-(33'(x_q)));
    t_cl   = (t_abs > 33'(29'h1000_0000)) ? 29'h1000_0000 : t_abs[28:0];
    t_prod = TPW'(t_cl) * TPW'(EXP_TABLE_DEPTH - 1) + (TPW'(1) << 27);
    ti     = TIW'(t_prod >> 28);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_en) begin
      e_q  <= (x_q >= 0) ? 17'd65536 : exp_rom[ti];
      pb_q <= p_q * b_q;
    end
  end

  // State update
  logic signed [49:0] eo;
  logic signed [33:0] eo_r;
  logic signed [28:0] pb_r;
  logic signed [34:0] hs;
  logic hov_q;
  always_comb begin
    eo   = $signed({1'b0, e_q}) * (start_q ? 32'sd0 : old_q);
    eo_r = 34'((51'(eo) + 51'sd32768) >>> 16);
    pb_r = 29'((49'(pb_q) + 49'sd524288) >>> 20);
    hs   = 35'(eo_r) + 35'(pb_r);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en) begin
      if (hs > 35'sd2147483647) begin
        h_q <= 32'sh7fff_ffff; hov_q <= 1'b1;
      end else if (hs < -35'sd2147483648) begin
        h_q <= 32'sh8000_0000; hov_q <= 1'b1;
      end else begin
        h_q <= 32'(hs); hov_q <= 1'b0;
      end
    end
  end

  // Accumulate
  logic signed [47:0] hc;
  logic signed [35:0] hc_r;
  logic signed [40:0] acc_sum;
  logic signed [39:0] acc_q, acc_base;
  logic sticky_q, acc_sat;
  always_comb begin
    hc       = h_q * c_q;
    hc_r     = 36'((49'(hc) + 49'sd2048) >>> 12);
    acc_base = first_q ? 40'sd0 : acc_q;
    acc_sum  = 41'(acc_base) + 41'(hc_r);
    acc_sat  = (acc_sum > 41'sh0_7f_ffff_ffff) || (acc_sum < -41'sh0_80_0000_0000);
  end

  // Emit
  logic signed [40:0] y_sum;
  assign y_sum = 41'(acc_q) + 41'(ud_q);

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_en) begin
        if (acc_sum > 41'sh0_7f_ffff_ffff) acc_q <= 40'sh7f_ffff_ffff;
        else if (acc_sum < -41'sh0_80_0000_0000) acc_q <= 40'sh80_0000_0000;
        else acc_q <= 40'(acc_sum);
        sticky_q <= (first_q ? 1'b0 : sticky_q) | hov_q | acc_sat;
      end else if (cmd_i.emit_en) begin
        acc_q    <= '0;
        sticky_q <= 1'b0;
      end
      if (cmd_i.emit_en) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      if (y_sum > 41'sd2147483647) begin
        y_o <= 32'sh7fff_ffff; ovf_o <= 1'b1;
      end else if (y_sum < -41'sd2147483648) begin
        y_o <= 32'sh8000_0000; ovf_o <= 1'b1;
      end else begin
        y_o <= 32'(y_sum); ovf_o <= sticky_q;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.skip     = (idx9 >= nsz);
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

[verif/tb_selective_state_space_scan_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective scan unit testbench
// Drives element beats with random gaps, stalls the output at random and
// compares every output beat with a behavioral model of the fixed-point scan.
// Covers several state sizes (0, 1, 16, 31 among them) and directed corners.
// ----------------------------------------------------------------------------
module tb_selective_state_space_scan_unit;
  import sss_pkg::*;

  localparam int MaxSt      = 16;
  localparam int ExpDepth   = 256;
  localparam int ItemTarget = 1950;
  localparam longint CycleLimit = 400000;
  localparam longint Q24One = 64'sd1 << 24;

  typedef struct {
    logic signed [15:0] u, dl, a, b, c, d;
    logic [3:0] idx;
    logic st;
  } elem_beat_t;

  typedef struct {
    logic signed [31:0] y;
    logic ovf;
  } scan_out_t;

  // directed rows: beat plus an optional typed-in expectation
  typedef struct {
    elem_beat_t beat;
    logic       has_exp;
    scan_out_t  exp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [StateSizeW-1:0] cfg_wdata_i = '0;

  sss_in_if  in_if();
  sss_out_if out_if();

  selective_state_space_scan_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_if), .out_o(out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model state
  logic [16:0]        decay_lut [ExpDepth];
  logic signed [31:0] h_mem [MaxSt];
  longint             dot_acc;
  bit                 sticky_ovf;
  int                 size_reg;
  scan_out_t          pending_y [$];
  int                 err_cnt = 0;
  int                 out_cnt = 0;
  longint             cyc = 0;
  bit                 quiet = 1'b0;
  bit                 sink_stall_en = 1'b1;
  int                 stall_left = 0;

  // Exponential in Q0.16 for t in Q8.24, same integer procedure as the table.
  function automatic logic [16:0] exp_q16(input longint t);
    longint y, term, sum;
    longint unsigned s;
    y = t >>> 2;
    term = 64'sd1 <<< 30;
    sum = term;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * y) >>> 30) / k;
      sum = (k % 2 == 1) ? sum - term : sum + term;
    end
    s = (sum < 0) ? 64'd0 : 64'(sum);
    for (int k = 0; k < 8; k++) s = (s * s + (64'd1 << 29)) >> 30;
    s = (s + (64'd1 << 13)) >> 14;
    return s[16:0];
  endfunction

  function automatic longint rshift_round(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                   inout bit ov);
    if (v > hi) begin
      ov = 1'b1;
      return hi;
    end
    if (v < lo) begin
      ov = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic int eff_size();
    if (size_reg < 1) return 1;
    if (size_reg > MaxSt) return MaxSt;
    return size_reg;
  endfunction

  // Advance the scan by one element; queue the output when the step closes.
  task automatic scan_element(input elem_beat_t bt);
    longint x, e, t, ti, old, h, y;
    bit ov;
    int n;
    scan_out_t r;
    ov = 1'b0;
    n = eff_size();
    if (int'(bt.idx) >= n) return;
    if (bt.idx == 0) begin
      dot_acc = 0;
      sticky_ovf = 1'b0;
    end
    x = longint'(bt.dl) * longint'(bt.a);
    if (x >= 0) e = 65536;
    else begin
      t = -x;
      if (t > 16 * Q24One) t = 16 * Q24One;
      ti = (t * (ExpDepth - 1) + 8 * Q24One) / (16 * Q24One);
      e = longint'(decay_lut[ti]);
    end
    old = bt.st ? 0 : longint'(h_mem[bt.idx]);
    h = rshift_round(e * old, 16) +
        rshift_round(longint'(bt.dl) * longint'(bt.u) * longint'(bt.b), 20);
    h = clamp(h, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1, ov);
    h_mem[bt.idx] = h[31:0];
    dot_acc = clamp(dot_acc + rshift_round(h * longint'(bt.c), 12),
                    -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1, ov);
    if (ov) sticky_ovf = 1'b1;
    if (int'(bt.idx) != n - 1) return;
    y = clamp(dot_acc + rshift_round(longint'(bt.u) * longint'(bt.d), 8),
              -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1, ov);
    r.y = y[31:0];
    r.ovf = sticky_ovf | ov;
    pending_y.push_back(r);
    dot_acc = 0;
    sticky_ovf = 1'b0;
  endtask

  // Put one beat on the input and hold it until taken.
  task automatic send_beat(input elem_beat_t bt);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.u_sample          <= bt.u;
    in_if.step_size         <= bt.dl;
    in_if.decay_rate        <= bt.a;
    in_if.b_value           <= bt.b;
    in_if.c_value           <= bt.c;
    in_if.skip_gain         <= bt.d;
    in_if.elem_index        <= bt.idx;
    in_if.start_of_sequence <= bt.st;
    do @(posedge clk_i); while (!in_if.ready);
    scan_element(bt);
  endtask

  task automatic drain_and_write(input int val);
    in_if.valid <= 1'b0;
    while (pending_y.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val[StateSizeW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = val;
  endtask

  function automatic elem_beat_t rand_beat(input int idx, input bit st);
    elem_beat_t bt;
    int mode;
    mode = $urandom_range(0, 9);
    bt.u  = 16'($urandom);
    bt.dl = 16'($urandom);
    bt.a  = 16'($urandom);
    bt.b  = 16'($urandom);
    bt.c  = 16'($urandom);
    bt.d  = 16'($urandom);
    if (mode < 6) begin
      // moderate magnitudes keep the state in range most of the time
      bt.u  = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      bt.dl = 16'($urandom_range(0, 4096));
      bt.a  = -$signed(16'($urandom_range(0, 16384)));
      bt.c  = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
    end
    bt.idx = idx[3:0];
    bt.st  = st;
    return bt;
  endfunction

  // Random sequence: well-formed steps, with some stray out-of-range beats.
  task automatic run_steps(input int n_items);
    int n, sent;
    bit first;
    elem_beat_t bt;
    n = eff_size();
    sent = 0;
    first = 1'b1;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) first = 1'b1;
      for (int i = 0; i < n; i++) begin
        bt = rand_beat(i, first || ($urandom_range(0, 15) == 0));
        send_beat(bt);
        sent++;
        if (n < MaxSt && $urandom_range(0, 9) == 0) begin
          bt = rand_beat(int'($urandom_range(n, 15)), 1'($urandom_range(0, 1)));
          send_beat(bt);
        end
      end
      first = 1'b0;
    end
  endtask

  function automatic dir_row_t mk_row(input logic signed [15:0] u, dl, a, b, c, d,
                                      input int idx, input bit st, input bit he,
                                      input logic signed [31:0] y, input bit ov);
    dir_row_t r;
    r.beat.u = u;  r.beat.dl = dl; r.beat.a = a; r.beat.b = b;
    r.beat.c = c;  r.beat.d = d;   r.beat.idx = idx[3:0]; r.beat.st = st;
    r.has_exp = he; r.exp.y = y;   r.exp.ovf = ov;
    return r;
  endfunction

  // Output side: random stalls, compare each beat with the oldest expectation.
  always @(posedge clk_i) begin
    scan_out_t exp_r;
    cyc <= cyc + 1;
    if (rst_ni && out_if.valid && out_if.ready) begin
      out_cnt <= out_cnt + 1;
      if (pending_y.size() == 0) begin
        $display("%0t: unexpected output y=%0d ovf=%0b", $time, out_if.y_out,
                 out_if.overflow);
        err_cnt <= err_cnt + 1;
      end else begin
        exp_r = pending_y.pop_front();
        if (out_if.y_out !== exp_r.y || out_if.overflow !== exp_r.ovf) begin
          $display("%0t: mismatch expected y=%0d ovf=%0b actual y=%0d ovf=%0b", $time,
                   exp_r.y, exp_r.ovf, out_if.y_out, out_if.overflow);
          err_cnt <= err_cnt + 1;
        end
      end
    end
    // random stall bursts, each ending with ready raised again before the next can start
    if (!quiet && stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!quiet && sink_stall_en && out_if.ready && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= int'($urandom_range(0, 4));
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cyc > CycleLimit) begin
      $display("timeout after %0d cycles", cyc);
      $display("end of test: mismatches");
      $finish;
    end
  end

  dir_row_t dir_rows [$];

  initial begin
    int sizes [6] = '{16, 1, 0, 31, 5, 16};
    in_if.valid = 1'b0;
    in_if.u_sample = '0; in_if.step_size = '0; in_if.decay_rate = '0;
    in_if.b_value = '0;  in_if.c_value = '0;   in_if.skip_gain = '0;
    in_if.elem_index = '0; in_if.start_of_sequence = 1'b0;
    out_if.ready = 1'b1;
    for (int i = 0; i < ExpDepth; i++)
      decay_lut[i] = exp_q16((longint'(i) * 16 * Q24One + (ExpDepth - 1) / 2) /
                             (ExpDepth - 1));
    foreach (h_mem[i]) h_mem[i] = '0;
    dot_acc = 0;
    sticky_ovf = 1'b0;
    size_reg = StateSizeReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: size 1 so each beat closes a step and outputs read off easily.
    drain_and_write(1);
    // zero everything: y = 0
    dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
    // only skip path: u=1.0 d=1.0 -> y = 1.0 in Q8.16
    dir_rows.push_back(mk_row(16'sd4096, 0, 0, 0, 0, 16'sd4096, 0, 1, 1, 32'sd65536, 0));
    // skip extremes: -8 * -8 = 64.0, still inside the Q8.16 range
    dir_rows.push_back(mk_row(-16'sd32768, 0, 0, 0, 0, -16'sd32768, 0, 1, 1,
                              32'sd4194304, 0));
    dir_rows.push_back(mk_row(16'sd32767, 0, 0, 0, 0, -16'sd32768, 0, 1, 0, 0, 0));
    // full-scale state update and extreme products
    dir_rows.push_back(mk_row(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                              16'sd32767, 0, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768,
                              -16'sd32768, 16'sd32767, 0, 0, 0, 0, 0));
    // decay past the table end, and positive argument (no decay)
    dir_rows.push_back(mk_row(16'sd4096, 16'sd32767, -16'sd32768, 16'sd4096, 16'sd4096,
                              0, 0, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096,
                              0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(16'sd4096, 16'sd4096, -16'sd4096, 16'sd4096, 16'sd4096,
                              16'sd4096, 0, 0, 0, 0, 0));
    // beyond the active size: dropped, no output
    dir_rows.push_back(mk_row(16'sd4096, 16'sd4096, 0, 16'sd4096, 16'sd4096, 0,
                              15, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(16'sd100, 16'sd200, -16'sd300, 16'sd400, 16'sd500,
                              16'sd600, 0, 0, 0, 0, 0));
    foreach (dir_rows[k]) begin
      send_beat(dir_rows[k].beat);
      // replace the model result with the typed-in one where it is given
      if (dir_rows[k].has_exp && pending_y.size() != 0)
        pending_y[pending_y.size() - 1] = dir_rows[k].exp;
    end

    // Directed at full size: index 0 restarts a step midway.
    drain_and_write(16);
    for (int i = 0; i < 16; i++) send_beat(rand_beat(i, 1'b1));
    for (int i = 0; i < 5; i++) send_beat(rand_beat(i, 1'b0));
    for (int i = 0; i < 16; i++) send_beat(rand_beat(i, 1'b0));

    // Random phases over several sizes; the last one runs without idling.
    foreach (sizes[s]) begin
      drain_and_write(sizes[s]);
      if (s == 5) quiet = 1'b1;
      run_steps(ItemTarget / 6);
    end

    in_if.valid <= 1'b0;
    while (pending_y.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d output beats over state sizes 0, 1, 5, 16 and 31,", out_cnt);
    $display("with random input gaps and output stalls, plus directed corners");
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
